[rtl/core/ars_pkg.sv]
// ars_pkg: field widths, operation and register codes, and the shared
// evaluation unit request/response types for the activity region segmenter.
// No dependencies.
`timescale 1ns / 1ps

package ars_pkg;

	localparam int OP_W       = 2;
	localparam int OFF_W      = 10;
	localparam int GPOS_W     = 32;
	localparam int PROB_W     = 16;
	localparam int SIZE_W     = 10;
	localparam int PROP_W     = 8;
	localparam int ENT_W      = 10;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 16;

	// item operations
	localparam logic [OP_W-1:0] OP_ADD   = 2'd0;
	localparam logic [OP_W-1:0] OP_POP   = 2'd1;
	localparam logic [OP_W-1:0] OP_CLEAR = 2'd2;
	localparam logic [OP_W-1:0] OP_NOP   = 2'd3;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_MAX_SIZE  = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_MIN_SIZE  = 2'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_PROP_DIST = 2'd3;

	// configuration reset values
	localparam logic [PROB_W-1:0] THRESHOLD_RST = 16'd33;
	localparam logic [SIZE_W-1:0] MAX_SIZE_RST  = 10'd300;
	localparam logic [SIZE_W-1:0] MIN_SIZE_RST  = 10'd50;
	localparam logic [PROP_W-1:0] PROP_DIST_RST = 8'd50;

	// best-minimum tracker starts above any stored value
	localparam logic [PROB_W:0] BEST_INIT = 17'h10000;

	typedef struct packed {
		logic [PROB_W-1:0] data;    // value just read from the window
		logic [PROB_W-1:0] v1;      // candidate minimum
		logic [PROB_W-1:0] v2;      // right-hand neighbour of the candidate
		logic [PROB_W-1:0] thr;     // activity threshold
		logic [PROB_W-1:0] addend;  // probability to accumulate
		logic [PROB_W:0]   bestp;   // lowest minimum found so far
	} eval_req_t;

	typedef struct packed {
		logic              above;       // data above threshold
		logic [PROB_W-1:0] sat_sum;     // data + addend, saturated
		logic              below_best;  // v1 below bestp
		logic              local_min;   // v1 <= v2 and v1 < data
	} eval_rsp_t;

endpackage

[rtl/core/ars_if.sv]
// ars_if: item and result channel interfaces (valid/ready with payload).
// Depends on ars_pkg for field widths.
`timescale 1ns / 1ps

interface ars_item_if import ars_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [OP_W-1:0]   op;
	logic [OFF_W-1:0]  offset;
	logic [GPOS_W-1:0] genomic_position;
	logic [PROB_W-1:0] probability;
	logic              force_req;

	modport source (output valid, op, offset, genomic_position, probability, force_req,
		input ready);
	modport sink (input valid, op, offset, genomic_position, probability, force_req,
		output ready);
endinterface

interface ars_result_if import ars_pkg::*; ();
	logic              valid;
	logic              ready;
	logic              region_found;
	logic              region_active;
	logic [GPOS_W-1:0] region_start;
	logic [GPOS_W-1:0] region_end;
	logic [ENT_W-1:0]  entries_left;

	modport source (output valid, region_found, region_active, region_start, region_end,
		entries_left, input ready);
	modport sink (input valid, region_found, region_active, region_start, region_end,
		entries_left, output ready);
endinterface

[rtl/core/ars_ram.sv]
// ars_ram: generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps

module ars_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 512
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

[rtl/core/ars_eval.sv]
// ars_eval: shared compare/add unit, reused by the add-write, run-scan and cut-site steps
// of the sequencer: threshold test, saturating accumulate, best and local-minimum tests.
// Depends on ars_pkg.
`timescale 1ns / 1ps

module ars_eval import ars_pkg::*; (
	input  eval_req_t req,
	output eval_rsp_t rsp
);

	logic [PROB_W:0] sum;

	assign sum = {1'b0, req.data} + {1'b0, req.addend};

	always_comb begin
		rsp.above      = req.data > req.thr;
		rsp.sat_sum    = sum[PROB_W] ? {PROB_W{1'b1}} : sum[PROB_W-1:0];
		rsp.below_best = {1'b0, req.v1} < req.bestp;
		rsp.local_min  = (req.v1 <= req.v2) && (req.v1 < req.data);
	end

endmodule

[rtl/core/activity_region_segmenter.sv]
// Activity region segmenter: window of activity probabilities in a ring RAM,
// add / pop / clear items, one result item per input item.
// Sequencing: clear, no-op, append and a pop that cuts nothing go straight to the result
// stage; an add onto a stored entry first reads the entry, then writes the sum. A cutting
// pop scans the run, one entry per cycle through the RAM read port, and, when an active run
// hits the maximum size, then searches for the cut site. One item at a time.
// Reset clears window state and loads register defaults; RAM contents stay undefined.
`timescale 1ns / 1ps

module activity_region_segmenter import ars_pkg::*; #(
	parameter int WINDOW_DEPTH = 512
) (
	input  logic                  clk,
	input  logic                  arst_n,
	ars_item_if.sink              item_ch,
	ars_result_if.source          result_ch,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	localparam int IDX_W = $clog2(WINDOW_DEPTH);
	localparam int CNT_W = $clog2(WINDOW_DEPTH + 1);
	// compare width covering count and max + propagation
	localparam int CW    = (CNT_W > SIZE_W + 1) ? CNT_W : SIZE_W + 1;

	localparam logic [2:0] S_IDLE   = 3'd0;
	localparam logic [2:0] S_ADD_WR = 3'd1;
	localparam logic [2:0] S_RUN    = 3'd2;
	localparam logic [2:0] S_SITE   = 3'd3;
	localparam logic [2:0] S_FIN    = 3'd4;

	// ring slot of window index i; i never reaches twice the depth
	function automatic logic [IDX_W-1:0] slot_f(input logic [IDX_W-1:0] base,
		input logic [CNT_W-1:0] i);
		logic [CNT_W:0] sum;
		sum = (CNT_W+1)'(base) + (CNT_W+1)'(i);
		if (sum >= (CNT_W+1)'(WINDOW_DEPTH)) begin
			sum = sum - (CNT_W+1)'(WINDOW_DEPTH);
		end
		return sum[IDX_W-1:0];
	endfunction

	logic [2:0]        state_q;
	logic [PROB_W-1:0] thr_q;
	logic [SIZE_W-1:0] max_q;
	logic [SIZE_W-1:0] min_q;
	logic [PROP_W-1:0] prop_q;

	logic [IDX_W-1:0]  head_q;
	logic [CNT_W-1:0]  count_q;
	logic [GPOS_W-1:0] wsp_q;
	logic              start_known_q;

	logic [PROB_W-1:0] prob_q;
	logic [IDX_W-1:0]  addr_q;
	logic              cut_q;
	logic              active_q;
	logic [CNT_W-1:0]  e_q;
	logic [CNT_W-1:0]  j_q;
	logic [CNT_W-1:0]  best_q;
	logic [PROB_W:0]   bestp_q;
	logic [PROB_W-1:0] v1_q;
	logic [PROB_W-1:0] v2_q;

	logic              out_valid_q;
	logic              found_q;
	logic              act_out_q;
	logic [GPOS_W-1:0] rstart_q;
	logic [GPOS_W-1:0] rend_q;
	logic [ENT_W-1:0]  left_q;

	logic              ram_we;
	logic [IDX_W-1:0]  ram_waddr;
	logic [PROB_W-1:0] ram_wdata;
	logic [IDX_W-1:0]  ram_raddr;
	logic [PROB_W-1:0] ram_rdata;

	eval_req_t         ev_req;
	eval_rsp_t         ev_rsp;

	logic              accept;
	logic              out_free;
	logic [OFF_W-2:0]  off_mag;
	logic              off_in_win;
	logic              can_append;
	logic              pop_cut;
	logic [CW-1:0]     lim;
	logic [SIZE_W-1:0] lo_c;

	logic              act_c;
	logic              match;
	logic [CNT_W-1:0]  e_inc;
	logic [CNT_W-1:0]  e_fin;
	logic              run_stop;
	logic              go_site;

	logic              cand;
	logic              take;
	logic [CNT_W-1:0]  best_nxt;
	logic              site_done;

	logic [CNT_W-1:0]  count_left;

	assign accept   = item_ch.valid && item_ch.ready;
	assign out_free = !out_valid_q || result_ch.ready;
	assign item_ch.ready = (state_q == S_IDLE);

	assign result_ch.valid         = out_valid_q;
	assign result_ch.region_found  = found_q;
	assign result_ch.region_active = act_out_q;
	assign result_ch.region_start  = rstart_q;
	assign result_ch.region_end    = rend_q;
	assign result_ch.entries_left  = left_q;

	// add and pop decisions on the incoming item
	assign off_mag    = item_ch.offset[OFF_W-2:0];
	assign off_in_win = CW'(off_mag) < CW'(count_q);
	assign can_append = CW'(count_q) < CW'(WINDOW_DEPTH);
	assign pop_cut    = (count_q != '0) && (max_q != '0) &&
		(item_ch.force_req || (CW'(count_q) >= CW'(max_q) + CW'(prop_q)));
	assign lim  = (CW'(count_q) < CW'(max_q)) ? CW'(count_q) : CW'(max_q);
	// lowest candidate index of the cut-site search
	assign lo_c = (min_q <= SIZE_W'(2)) ? SIZE_W'(1) : min_q - SIZE_W'(1);

	// run scan step: data of index e_q arrives this cycle
	assign act_c    = (e_q == '0) ? ev_rsp.above : active_q;
	assign match    = (ev_rsp.above == act_c);
	assign e_inc    = e_q + CNT_W'(1);
	assign e_fin    = match ? e_inc : e_q;
	assign run_stop = !match || (CW'(e_inc) == lim);
	assign go_site  = act_c && (CW'(e_fin) == CW'(max_q)) && (CW'(lo_c) < CW'(e_fin));

	// cut-site step: data of index j_q arrives, candidate is j_q + 1
	assign cand      = (CW'(j_q) + CW'(2) <= CW'(e_q)) && (CW'(j_q) + CW'(2) < CW'(count_q));
	assign take      = cand && ev_rsp.local_min && ev_rsp.below_best;
	assign best_nxt  = take ? j_q + CNT_W'(1) : best_q;
	assign site_done = (CW'(j_q) + CW'(1) == CW'(lo_c));

	assign count_left = cut_q ? count_q - e_q : count_q;

	// shared unit operands
	always_comb begin
		ev_req.data   = ram_rdata;
		ev_req.v1     = v1_q;
		ev_req.v2     = v2_q;
		ev_req.thr    = thr_q;
		ev_req.addend = prob_q;
		ev_req.bestp  = bestp_q;
	end

	ars_eval u_eval (
		.req (ev_req),
		.rsp (ev_rsp)
	);

	// RAM port control
	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = addr_q;
		ram_wdata = ev_rsp.sat_sum;
		ram_raddr = head_q;
		case (state_q)
			S_IDLE: begin
				if (accept && item_ch.op == OP_ADD && !item_ch.offset[OFF_W-1]) begin
					if (off_in_win) begin
						ram_raddr = slot_f(head_q, CNT_W'(off_mag));
					end else if (can_append) begin
						ram_we    = 1'b1;
						ram_waddr = slot_f(head_q, count_q);
						ram_wdata = item_ch.probability;
					end
				end
			end
			S_ADD_WR: begin
				ram_we = 1'b1;
			end
			S_RUN: begin
				ram_raddr = slot_f(head_q, e_inc);
			end
			S_SITE: begin
				ram_raddr = slot_f(head_q, j_q - CNT_W'(1));
			end
			default: begin
			end
		endcase
	end

	ars_ram #(
		.WIDTH (PROB_W),
		.DEPTH (WINDOW_DEPTH)
	) u_ring (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q  <= THRESHOLD_RST;
			max_q  <= MAX_SIZE_RST;
			min_q  <= MIN_SIZE_RST;
			prop_q <= PROP_DIST_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_THRESHOLD: thr_q  <= cfg_data;
				CFG_MAX_SIZE:  max_q  <= cfg_data[SIZE_W-1:0];
				CFG_MIN_SIZE:  min_q  <= cfg_data[SIZE_W-1:0];
				CFG_PROP_DIST: prop_q <= cfg_data[PROP_W-1:0];
				default: begin
				end
			endcase
		end
	end

	// sequencer and window state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= S_IDLE;
			head_q        <= '0;
			count_q       <= '0;
			wsp_q         <= '0;
			start_known_q <= 1'b0;
			prob_q        <= '0;
			addr_q        <= '0;
			cut_q         <= 1'b0;
			active_q      <= 1'b0;
			e_q           <= '0;
			j_q           <= '0;
			best_q        <= '0;
			bestp_q       <= BEST_INIT;
			v1_q          <= '0;
			v2_q          <= '0;
			out_valid_q   <= 1'b0;
			found_q       <= 1'b0;
			act_out_q     <= 1'b0;
			rstart_q      <= '0;
			rend_q        <= '0;
			left_q        <= '0;
		end else begin
			// result taken, unless a new one loads in the same cycle
			if (result_ch.ready && !(state_q == S_FIN && out_free)) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						cut_q  <= 1'b0;
						e_q    <= '0;
						prob_q <= item_ch.probability;
						addr_q <= slot_f(head_q, CNT_W'(off_mag));
						state_q <= S_FIN;
						case (item_ch.op)
							OP_ADD: begin
								if (!start_known_q) begin
									wsp_q         <= item_ch.genomic_position;
									start_known_q <= 1'b1;
								end
								if (!item_ch.offset[OFF_W-1]) begin
									if (off_in_win) begin
										state_q <= S_ADD_WR;
									end else if (can_append) begin
										count_q <= count_q + CNT_W'(1);
									end
								end
							end
							OP_POP: begin
								if (pop_cut) begin
									cut_q   <= 1'b1;
									state_q <= S_RUN;
								end
							end
							OP_CLEAR: begin
								head_q        <= '0;
								count_q       <= '0;
								wsp_q         <= '0;
								start_known_q <= 1'b0;
							end
							default: begin
							end
						endcase
					end
				end
				S_ADD_WR: begin
					state_q <= S_FIN;
				end
				S_RUN: begin
					active_q <= act_c;
					if (run_stop) begin
						e_q <= e_fin;
						if (go_site) begin
							j_q     <= e_fin;
							best_q  <= e_fin - CNT_W'(1);
							bestp_q <= BEST_INIT;
							state_q <= S_SITE;
						end else begin
							state_q <= S_FIN;
						end
					end else begin
						e_q <= e_inc;
					end
				end
				S_SITE: begin
					v1_q   <= ram_rdata;
					v2_q   <= v1_q;
					best_q <= best_nxt;
					if (take) begin
						bestp_q <= {1'b0, v1_q};
					end
					if (site_done) begin
						e_q     <= best_nxt + CNT_W'(1);
						state_q <= S_FIN;
					end else begin
						j_q <= j_q - CNT_W'(1);
					end
				end
				S_FIN: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
						found_q     <= cut_q;
						act_out_q   <= cut_q && active_q;
						rstart_q    <= cut_q ? wsp_q : '0;
						rend_q      <= cut_q ? wsp_q + GPOS_W'(e_q - CNT_W'(1)) : '0;
						left_q      <= ENT_W'(count_left);
						if (cut_q) begin
							head_q  <= slot_f(head_q, e_q);
							count_q <= count_left;
							if (count_left == '0) begin
								start_known_q <= 1'b0;
								wsp_q         <= '0;
							end else begin
								wsp_q <= wsp_q + GPOS_W'(e_q);
							end
						end
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// window never overfills
	assert property (@(posedge clk) disable iff (!arst_n)
		CW'(count_q) <= CW'(WINDOW_DEPTH))
		else $error("window entry count above depth");

	// a stored entry always has a known start
	assert property (@(posedge clk) disable iff (!arst_n)
		(count_q != '0) |-> start_known_q)
		else $error("entries held without a start position");

	// an accepted item always enters the sequencer
	assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> (state_q != S_IDLE))
		else $error("accepted item not processed");

	// cut site stays inside the run being searched
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_SITE) |-> (best_q < e_q))
		else $error("cut site beyond run end");

	// a cut never removes more entries than the window holds
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_FIN && cut_q) |-> (e_q != '0 && e_q <= count_q))
		else $error("cut length out of range");

endmodule

[sim/tb_activity_region_segmenter.sv]
// tb_activity_region_segmenter: self-checking bench that drives add, pop, clear and no-op
// items and predicts every result item from its own copy of the window.
// Depends on ars_pkg, ars_if and activity_region_segmenter.
`timescale 1ns / 1ps

module tb_activity_region_segmenter;
	import ars_pkg::*;

	localparam int WINDOW      = 512;
	localparam int STALL_LIMIT = 20000;
	localparam int PRINT_LIMIT = 40;

	typedef struct packed {
		logic [OP_W-1:0]   op;
		logic [OFF_W-1:0]  offset;
		logic [GPOS_W-1:0] gpos;
		logic [PROB_W-1:0] prob;
		logic              force_req;
	} seg_item_t;

	typedef struct packed {
		logic              found;
		logic              active;
		logic [GPOS_W-1:0] rstart;
		logic [GPOS_W-1:0] rend;
		logic [ENT_W-1:0]  left;
	} region_rpt_t;

	logic                  clk       = 1'b0;
	logic                  arst_n    = 1'b0;
	logic                  cfg_we    = 1'b0;
	logic [CFG_IDX_W-1:0]  cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data  = '0;

	ars_item_if   item_bus ();
	ars_result_if result_bus ();

	// window copy used for prediction
	logic [PROB_W-1:0] win_prob [WINDOW];
	int unsigned       win_head      = 0;
	int unsigned       win_count     = 0;
	logic [GPOS_W-1:0] win_start     = '0;
	bit                start_latched = 1'b0;

	// register copies, reset values
	int unsigned act_thr     = THRESHOLD_RST;
	int unsigned max_len_cfg = MAX_SIZE_RST;
	int unsigned min_len_cfg = MIN_SIZE_RST;
	int unsigned prop_cfg    = PROP_DIST_RST;

	region_rpt_t region_q [$];
	region_rpt_t due_rpt;
	int          err_count    = 0;
	int          tx_idle_pct  = 0;
	int          rx_idle_pct  = 0;
	int          rx_hold_req  = 0;
	int          rx_hold_left = 0;
	int          quiet_cycles = 0;

	activity_region_segmenter #(
		.WINDOW_DEPTH(WINDOW)
	) dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.item_ch  (item_bus),
		.result_ch(result_bus),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data)
	);

	always #5 clk = ~clk;

	task automatic flag_error(string msg);
		if (err_count < PRINT_LIMIT) begin
			$display("ERROR %0t ns: %s", $time, msg);
		end
		err_count++;
	endtask

	function automatic int unsigned prob_at(int unsigned i);
		return win_prob[(win_head + i) % WINDOW];
	endfunction

	// next state of the window and the result item for one accepted item
	function automatic region_rpt_t segment_step(seg_item_t it);
		region_rpt_t rpt;
		int unsigned off, sum, run, lo, best, bestp, i;
		bit          act;
		rpt = '0;
		case (it.op)
			OP_ADD: begin
				if (!start_latched) begin
					win_start     = it.gpos;
					start_latched = 1'b1;
				end
				off = it.offset;
				// negative offsets are dropped
				if (!it.offset[OFF_W-1]) begin
					if (off < win_count) begin
						sum = prob_at(off) + it.prob;
						win_prob[(win_head + off) % WINDOW] = (sum > 65535) ? 16'hFFFF : PROB_W'(sum);
					end else if (win_count < WINDOW) begin
						win_prob[(win_head + win_count) % WINDOW] = it.prob;
						win_count++;
					end
				end
			end
			OP_POP: begin
				if (win_count > 0 && max_len_cfg > 0 &&
						(it.force_req || win_count >= max_len_cfg + prop_cfg)) begin
					act = prob_at(0) > act_thr;
					run = 0;
					while (run < win_count && run < max_len_cfg && ((prob_at(run) > act_thr) == act))
						run++;
					// long active run: cut after the deepest valley past the minimum length
					if (act && run == max_len_cfg) begin
						lo    = (min_len_cfg > 0) ? min_len_cfg - 1 : 0;
						best  = run - 1;
						bestp = 32'h10000;
						i     = run;
						while (i > lo) begin
							i--;
							if (prob_at(i) < bestp && i >= 1 && i + 1 < win_count &&
									prob_at(i) <= prob_at(i + 1) && prob_at(i) < prob_at(i - 1)) begin
								bestp = prob_at(i);
								best  = i;
							end
						end
						run = best + 1;
					end
					rpt.found  = 1'b1;
					rpt.active = act;
					rpt.rstart = win_start;
					rpt.rend   = win_start + run - 1;
					win_head   = (win_head + run) % WINDOW;
					win_count -= run;
					if (win_count == 0) begin
						start_latched = 1'b0;
						win_start     = '0;
					end else begin
						win_start += run;
					end
				end
			end
			OP_CLEAR: begin
				win_head      = 0;
				win_count     = 0;
				win_start     = '0;
				start_latched = 1'b0;
			end
			default: ;
		endcase
		rpt.left = ENT_W'(win_count);
		return rpt;
	endfunction

	// offer one item, wait for it to be taken, then predict its result
	task automatic send_item(logic [OP_W-1:0] op, logic [OFF_W-1:0] off,
			logic [GPOS_W-1:0] gpos, logic [PROB_W-1:0] prob, logic frc);
		seg_item_t it;
		it = {op, off, gpos, prob, frc};
		while ($urandom_range(99) < tx_idle_pct) begin
			item_bus.valid <= 1'b0;
			@(posedge clk);
		end
		item_bus.valid            <= 1'b1;
		item_bus.op               <= op;
		item_bus.offset           <= off;
		item_bus.genomic_position <= gpos;
		item_bus.probability      <= prob;
		item_bus.force_req        <= frc;
		@(posedge clk);
		while (!item_bus.ready) @(posedge clk);
		region_q.push_back(segment_step(it));
	endtask

	// stop offering and wait for every predicted result item
	task automatic drain();
		item_bus.valid <= 1'b0;
		while (region_q.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		@(posedge clk);
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	task automatic set_config(logic [PROB_W-1:0] thr, logic [SIZE_W-1:0] max_len,
			logic [SIZE_W-1:0] min_len, logic [PROP_W-1:0] prop);
		drain();
		write_reg(CFG_THRESHOLD, thr);
		write_reg(CFG_MAX_SIZE, CFG_DATA_W'(max_len));
		write_reg(CFG_MIN_SIZE, CFG_DATA_W'(min_len));
		write_reg(CFG_PROP_DIST, CFG_DATA_W'(prop));
		act_thr     = thr;
		max_len_cfg = max_len;
		min_len_cfg = min_len;
		prop_cfg    = prop;
	endtask

	// mostly runs of active / inactive appends with pops, some accumulates and noise
	task automatic random_items(int n);
		int unsigned r, off;
		bit          hi;
		logic [PROB_W-1:0] p;
		hi = 1'b0;
		repeat (n) begin
			r = $urandom_range(99);
			if ($urandom_range(7) == 0) hi = !hi;
			if (r < 55) begin
				off = (win_count >= 508) ? 511 : win_count + $urandom_range(3, 0);
				if ($urandom_range(15) == 0) p = PROB_W'($urandom);
				else if (hi && act_thr < 65535) p = PROB_W'($urandom_range(65535, act_thr + 1));
				else p = PROB_W'($urandom_range(act_thr, 0));
				send_item(OP_ADD, OFF_W'(off), $urandom, p, 1'($urandom));
			end else if (r < 70 && win_count > 0) begin
				send_item(OP_ADD, OFF_W'($urandom_range(win_count - 1, 0)), $urandom,
					PROB_W'($urandom_range(600, 0)), 1'($urandom));
			end else if (r < 88) begin
				send_item(OP_POP, OFF_W'($urandom), $urandom, PROB_W'($urandom),
					$urandom_range(3) == 0);
			end else if (r < 91) begin
				send_item(OP_CLEAR, OFF_W'($urandom), $urandom, PROB_W'($urandom), 1'($urandom));
			end else if (r < 94) begin
				send_item(OP_NOP, OFF_W'($urandom), $urandom, PROB_W'($urandom), 1'($urandom));
			end else begin
				send_item(OP_W'($urandom), OFF_W'($urandom), $urandom, PROB_W'($urandom),
					1'($urandom));
			end
		end
	endtask

	// reset register values, field extremes and the window edge cases
	task automatic test_directed();
		send_item(OP_POP, 10'd0, 32'h0, 16'h0, 1'b1);              // empty window
		send_item(OP_ADD, 10'h3FF, 32'hFFFF_FFF0, 16'd500, 1'b0);   // ignored, start latched
		send_item(OP_ADD, 10'd0, 32'h0, 16'd34, 1'b1);              // just above threshold
		send_item(OP_ADD, 10'h1FF, 32'h1234_5678, 16'hFFFF, 1'b0);  // far offset appends
		send_item(OP_ADD, 10'd1, 32'hAAAA_AAAA, 16'hFFFF, 1'b1);    // saturating sum
		send_item(OP_ADD, 10'd2, 32'h5555_5555, 16'd33, 1'b0);      // at threshold: inactive
		send_item(OP_ADD, 10'h200, 32'hFFFF_FFFF, 16'hFFFF, 1'b1);  // most negative offset
		send_item(OP_ADD, 10'd2, 32'h0, 16'd0, 1'b0);
		send_item(OP_NOP, 10'h3FF, 32'hFFFF_FFFF, 16'hFFFF, 1'b1);
		send_item(OP_POP, 10'h3FF, 32'hFFFF_FFFF, 16'hFFFF, 1'b0);  // too few entries
		send_item(OP_POP, 10'd0, 32'h0, 16'h0, 1'b1);               // active run of two
		send_item(OP_POP, 10'd0, 32'h0, 16'h0, 1'b1);               // empties the window
		send_item(OP_ADD, 10'd7, 32'h8000_0001, 16'h8000, 1'b0);
		send_item(OP_ADD, 10'd0, 32'h0, 16'h7FFF, 1'b0);
		send_item(OP_CLEAR, 10'h155, 32'h5555_5555, 16'h5555, 1'b1);
		send_item(OP_POP, 10'h2AA, 32'hAAAA_AAAA, 16'hAAAA, 1'b1);  // empty after clear
		send_item(OP_ADD, 10'd0, 32'hFFFF_FFFF, 16'd0, 1'b0);
		send_item(OP_ADD, 10'd1, $urandom, 16'd1000, 1'b0);
		send_item(OP_POP, 10'd0, 32'h0, 16'h0, 1'b1);               // inactive, single entry
		send_item(OP_POP, 10'd0, 32'h0, 16'h0, 1'b1);               // start wrapped to zero
	endtask

	// register extremes: zero sizes, minimum above maximum, top threshold
	task automatic test_config_corners();
		int unsigned vals [8] = '{200, 150, 120, 180, 130, 300, 400, 90};
		// zero maximum: nothing is ever cut
		set_config(16'd0, 10'd0, 10'd0, 8'd0);
		send_item(OP_ADD, 10'd0, $urandom, 16'd5, 1'b0);
		send_item(OP_ADD, 10'd1, $urandom, 16'd0, 1'b0);
		send_item(OP_POP, 10'd0, $urandom, 16'd0, 1'b0);
		send_item(OP_POP, 10'd0, $urandom, 16'd0, 1'b1);
		// zero minimum: valley search runs down to the front
		set_config(16'd100, 10'd6, 10'd0, 8'd0);
		send_item(OP_CLEAR, 10'd0, $urandom, 16'd0, 1'b0);
		foreach (vals[k]) send_item(OP_ADD, 10'd511, $urandom, PROB_W'(vals[k]), 1'b0);
		send_item(OP_POP, 10'd0, $urandom, 16'd0, 1'b0);
		// minimum above maximum: cut stays at the maximum
		set_config(16'd100, 10'd4, 10'd512, 8'd255);
		repeat (5) send_item(OP_ADD, 10'd511, $urandom, 16'd500, 1'b0);
		send_item(OP_POP, 10'd0, $urandom, 16'd0, 1'b0);
		send_item(OP_POP, 10'd0, $urandom, 16'd0, 1'b1);
		// top threshold: every entry is inactive
		set_config(16'hFFFF, 10'd512, 10'd1, 8'd255);
		repeat (3) send_item(OP_ADD, 10'd511, $urandom, 16'hFFFF, 1'b0);
		send_item(OP_POP, 10'd0, $urandom, 16'd0, 1'b1);
	endtask

	task automatic test_random(int n);
		int unsigned max_len;
		logic [PROB_W-1:0] thr;
		max_len = $urandom_range(24, 3);
		case ($urandom_range(5))
			0: begin
				thr = 16'd0;
			end
			1: begin
				thr = 16'hFFFF;
			end
			default: begin
				thr = PROB_W'($urandom_range(30000, 50));
			end
		endcase
		set_config(thr, SIZE_W'(max_len), SIZE_W'($urandom_range(max_len + 3, 1)),
			PROP_W'($urandom_range(12, 0)));
		random_items(n);
	endtask

	// result side held off while items keep coming, then a full pause
	task automatic test_backpressure();
		set_config(16'd2000, 10'd8, 10'd3, 8'd2);
		rx_hold_req = 400;
		random_items(30);
		drain();
		random_items(10);
	endtask

	// fill every slot, then cut with the largest region size
	task automatic test_full_window();
		set_config(16'd1000, 10'd512, 10'd1, 8'd0);
		while (win_count < WINDOW)
			send_item(OP_ADD, OFF_W'($urandom_range(511, win_count)), $urandom,
				PROB_W'($urandom_range(65535, 1001)), 1'($urandom));
		send_item(OP_ADD, 10'd511, $urandom, 16'd7, 1'b0);      // accumulate into the tail
		send_item(OP_POP, 10'd0, $urandom, 16'd0, 1'b0);
		while (win_count > 0) send_item(OP_POP, 10'd0, $urandom, 16'd0, 1'b1);
	endtask

	// result side: check each accepted item, then pick ready for the next edge
	always @(posedge clk) begin
		if (result_bus.valid && result_bus.ready) begin
			if (region_q.size() == 0) begin
				flag_error("result item arrived with no prediction waiting");
			end else begin
				due_rpt = region_q[0];
				region_q.delete(0);
				if (result_bus.region_found !== due_rpt.found)
					flag_error($sformatf("region_found %b, predicted %b",
						result_bus.region_found, due_rpt.found));
				if (result_bus.region_active !== due_rpt.active)
					flag_error($sformatf("region_active %b, predicted %b",
						result_bus.region_active, due_rpt.active));
				if (result_bus.region_start !== due_rpt.rstart)
					flag_error($sformatf("region_start %h, predicted %h",
						result_bus.region_start, due_rpt.rstart));
				if (result_bus.region_end !== due_rpt.rend)
					flag_error($sformatf("region_end %h, predicted %h",
						result_bus.region_end, due_rpt.rend));
				if (result_bus.entries_left !== due_rpt.left)
					flag_error($sformatf("entries_left %0d, predicted %0d",
						result_bus.entries_left, due_rpt.left));
			end
		end
		if (rx_hold_req > 0) begin
			rx_hold_left = rx_hold_req;
			rx_hold_req  = 0;
		end
		if (rx_hold_left > 0) begin
			rx_hold_left--;
			result_bus.ready <= 1'b0;
		end else begin
			result_bus.ready <= ($urandom_range(99) >= rx_idle_pct);
		end
	end

	// watchdog: too long without any item moving
	always @(posedge clk) begin
		if ((item_bus.valid && item_bus.ready) || (result_bus.valid && result_bus.ready))
			quiet_cycles = 0;
		else
			quiet_cycles++;
		if (quiet_cycles >= STALL_LIMIT) begin
			$display("Verification failed");
			$finish;
		end
	end

	initial begin
		item_bus.valid            = 1'b0;
		item_bus.op               = OP_NOP;
		item_bus.offset           = '0;
		item_bus.genomic_position = '0;
		item_bus.probability      = '0;
		item_bus.force_req        = 1'b0;
		result_bus.ready          = 1'b0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed();
		test_config_corners();
		tx_idle_pct = 18;
		rx_idle_pct = 86;
		repeat (2) test_random(60);
		tx_idle_pct = 86;
		rx_idle_pct = 18;
		repeat (2) test_random(60);
		tx_idle_pct = 0;
		rx_idle_pct = 0;
		repeat (2) test_random(60);
		test_backpressure();
		test_full_window();

		drain();
		repeat (20) @(posedge clk);
		if (err_count == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule

[activity_region_segmenter.f]
rtl/core/ars_pkg.sv
rtl/core/ars_if.sv
rtl/core/ars_ram.sv
rtl/core/ars_eval.sv
rtl/core/activity_region_segmenter.sv
sim/tb_activity_region_segmenter.sv
